// ===== hw/rtl/stable_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// stable_priority_queue assertion macros
// Concurrent assertion forms for the priority queue checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// property checked only while out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // number of entries held
  localparam int CAPACITY = 16;
  // count width, able to hold CAPACITY itself
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 8;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  // one queue entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } spq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic       shift_in;   // insert into a non-full queue
    logic       shift_out;  // remove from a non-empty queue
    spq_entry_t entry;      // entry being inserted
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, highest priority first, first in first out among
// equal priorities, built as a chain of shift-register cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one operation per beat:
//   insert (prio_in_i, tag_in_i) or remove the front entry.
//   Output channel (out_valid_o / out_ready_i) returns one result beat per
//   operation: status, removed tag and priority (zero unless removed) and the
//   fill level after the operation.
//   The result is registered on the edge that accepts the operation. Throughput
//   is one operation per cycle while results are taken; every cell compares
//   its priority with the new one in parallel and the chain shifts on that edge.
//   An insert into a full queue is dropped with status full; a removal from
//   an empty queue returns status empty.
//   When the receiver stalls, the result register holds and in_ready_o drops
//   until the result is taken; a new operation is taken in the same cycle the
//   pending result leaves.
//   Reset empties the queue and clears the result valid; entry contents and
//   the result payload are not cleared, only the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [PRIO_W-1:0] prio_in_i,
  input  wire logic [TAG_W-1:0]  tag_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [TAG_W-1:0]       tag_out_o,
  output logic [PRIO_W-1:0]      prio_out_o,
  output logic [FILL_W-1:0]      fill_level_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  spq_status_e       status_q, status_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [FILL_W-1:0] fill_q;

  logic       accept;
  logic       full;
  logic       empty;
  spq_cmd_t   cmd;
  spq_entry_t cell_entry  [CAPACITY];
  logic       cell_behind [CAPACITY];

  // input beat acceptance
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);

  // command broadcast to the chain
  assign cmd.shift_in   = accept && (operation_i == OP_INSERT) && !full;
  assign cmd.shift_out  = accept && (operation_i == OP_REMOVE) && !empty;
  assign cmd.entry.prio = prio_in_i;
  assign cmd.entry.tag  = tag_in_i;

  // chain of cells, front at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       left_behind;
    spq_entry_t left_entry;
    spq_entry_t right_entry;

    if (i == 0) begin : g_front
      assign left_behind = 1'b1;
      assign left_entry  = cmd.entry;
    end else begin : g_mid
      assign left_behind = cell_behind[i-1];
      assign left_entry  = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (CNT_W'(i) < count_q),
      .left_behind_i (left_behind),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .behind_o      (cell_behind[i])
    );
  end

  // count and result
  always_comb begin
    count_d  = count_q;
    status_d = ST_INSERTED;
    tag_d    = '0;
    prio_d   = '0;
    if (operation_i == OP_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_REMOVED;
        tag_d    = cell_entry[0].tag;
        prio_d   = cell_entry[0].prio;
        count_d  = count_q - CNT_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      prio_q   <= prio_d;
      fill_q   <= FILL_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign tag_out_o    = tag_q;
  assign prio_out_o   = prio_q;
  assign fill_level_o = fill_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift-register queue: keeps, takes the new entry,
// or takes a neighbor's entry, depending on the broadcast command.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire spq_cmd_t   cmd_i,
  input  wire logic       occupied_i,
  input  wire logic       left_behind_i,
  input  wire spq_entry_t left_entry_i,
  input  wire spq_entry_t right_entry_i,
  output spq_entry_t      entry_o,
  output logic            behind_o
);

  spq_entry_t entry_q, entry_d;

  // new entry goes behind every held entry of greater or equal priority
  assign behind_o = occupied_i && (entry_q.prio >= cmd_i.entry.prio);
  assign entry_o  = entry_q;

  // slot update
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift_in) begin
      if (!left_behind_i) begin
        entry_d = left_entry_i;
      end else if (!behind_o) begin
        entry_d = cmd_i.entry;
      end
    end else if (cmd_i.shift_out) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stable_priority_queue_assert.svh"

module spq_checker
  import spq_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              operation_i,
  input wire logic [PRIO_W-1:0] prio_in_i,
  input wire logic [TAG_W-1:0]  tag_in_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [TAG_W-1:0]  tag_out_o,
  input wire logic [PRIO_W-1:0] prio_out_o,
  input wire logic [FILL_W-1:0] fill_level_o
);

  logic unused_in;
  assign unused_in = ^{in_valid_i, in_ready_o, operation_i, prio_in_i, tag_in_i};

  // a stalled result beat holds
  `SPQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(tag_out_o) && $stable(prio_out_o) && $stable(fill_level_o), "result beat changed while stalled")

  // only a removal carries a tag and priority
  `SPQ_ASSERT(a_zero_payload, out_valid_o && (status_o != ST_REMOVED) |-> (tag_out_o == '0) && (prio_out_o == '0), "nonzero payload on a non-removal result")

  // empty and full results agree with the fill level
  `SPQ_ASSERT(a_fill_status, out_valid_o |-> ((status_o != ST_EMPTY) || (fill_level_o == '0)) && ((status_o != ST_FULL) || (fill_level_o == FILL_W'(CAPACITY))), "fill level disagrees with status")

  // no result beat during reset
  `SPQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stable priority queue: a behavioral queue
// predicts status, removed entry and fill level for every operation beat,
// with random idling on both channels, a long receiver hold-off and drains.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT     = 18;

  // one predicted result beat
  typedef struct packed {
    spq_status_e       status;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [FILL_W-1:0] fill;
  } spq_result_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b1;
  logic              in_valid_i   = 1'b0;
  logic              operation_i  = OP_INSERT;
  logic [PRIO_W-1:0] prio_in_i    = '0;
  logic [TAG_W-1:0]  tag_in_i     = '0;
  logic              out_ready_i  = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [TAG_W-1:0]  tag_out_o;
  logic [PRIO_W-1:0] prio_out_o;
  logic [FILL_W-1:0] fill_level_o;

  // sorted contents as the queue should hold them, front first
  spq_entry_t  queue_contents[$];
  spq_result_t pending_results[$];

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_request = 1'b0;

  int fail_count   = 0;
  int cycle_count  = 0;
  int n_inserted   = 0;
  int n_removed    = 0;
  int n_full_drops = 0;
  int n_empty_pops = 0;
  int n_checked    = 0;
  int peak_fill    = 0;

  stable_priority_queue i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .prio_in_i    (prio_in_i),
    .tag_in_i     (tag_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .tag_out_o    (tag_out_o),
    .prio_out_o   (prio_out_o),
    .fill_level_o (fill_level_o)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("stable_priority_queue test failed");
      $finish;
    end
  end

  // apply one operation to the queue contents and record its result
  function automatic void predict_queue_op(logic op, logic [PRIO_W-1:0] prio,
                                           logic [TAG_W-1:0] tag);
    spq_result_t res;
    spq_entry_t  ent;
    int          pos;
    res = '{status: ST_INSERTED, tag: '0, prio: '0, fill: '0};
    if (op == OP_INSERT) begin
      if (queue_contents.size() >= CAPACITY) begin
        res.status = ST_FULL;
        n_full_drops++;
      end else begin
        // new entry goes behind every entry of greater or equal priority
        pos = 0;
        while (pos < queue_contents.size() && queue_contents[pos].prio >= prio)
          pos++;
        ent.prio = prio;
        ent.tag  = tag;
        queue_contents.insert(pos, ent);
        n_inserted++;
      end
    end else if (queue_contents.size() == 0) begin
      res.status = ST_EMPTY;
      n_empty_pops++;
    end else begin
      res.status = ST_REMOVED;
      res.tag    = queue_contents[0].tag;
      res.prio   = queue_contents[0].prio;
      void'(queue_contents.pop_front());
      n_removed++;
    end
    res.fill = FILL_W'(queue_contents.size());
    if (queue_contents.size() > peak_fill) peak_fill = queue_contents.size();
    pending_results.push_back(res);
  endfunction

  // compare one result beat against the oldest prediction
  function automatic void compare_result();
    spq_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing expected: status %0d tag %0h prio %0h fill %0d",
             status_o, tag_out_o, prio_out_o, fill_level_o);
      fail_count++;
      return;
    end
    exp_res = pending_results.pop_front();
    n_checked++;
    if (status_o !== exp_res.status) begin
      $error("status: expected %0d, actual %0d", exp_res.status, status_o);
      fail_count++;
    end
    if (tag_out_o !== exp_res.tag) begin
      $error("tag_out: expected %0h, actual %0h", exp_res.tag, tag_out_o);
      fail_count++;
    end
    if (prio_out_o !== exp_res.prio) begin
      $error("prio_out: expected %0h, actual %0h", exp_res.prio, prio_out_o);
      fail_count++;
    end
    if (fill_level_o !== exp_res.fill) begin
      $error("fill_level: expected %0d, actual %0d", exp_res.fill, fill_level_o);
      fail_count++;
    end
  endfunction

  // monitor both channels; an input beat always precedes its result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_queue_op(operation_i, prio_in_i, tag_in_i);
      if (out_valid_o && out_ready_i) compare_result();
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (sink_idle_en) begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one operation beat and wait until it is taken
  task automatic send_beat(input logic op, input logic [PRIO_W-1:0] prio,
                           input logic [TAG_W-1:0] tag);
    int gap;
    if (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    prio_in_i   <= prio;
    tag_in_i    <= tag;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and wait until every predicted result has been checked
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // priority biased toward ties and the extremes
  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(3))
      0:       return PRIO_W'($urandom_range(3));
      1:       return PRIO_W'($urandom_range(255, 252));
      default: return PRIO_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_beat(input int insert_pct);
    logic op;
    op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    send_beat(op, pick_prio(), TAG_W'($urandom_range(16'hffff)));
  endtask

  // field extremes, empty removal and first in first out among ties
  task automatic test_directed();
    send_beat(OP_REMOVE, '0, '0);
    send_beat(OP_INSERT, 8'h00, 16'h0000);
    send_beat(OP_INSERT, 8'hff, 16'hffff);
    send_beat(OP_INSERT, 8'h80, 16'h1111);
    send_beat(OP_INSERT, 8'h80, 16'h2222);
    send_beat(OP_INSERT, 8'h80, 16'h3333);
    send_beat(OP_INSERT, 8'h81, 16'h4444);
    repeat (6) send_beat(OP_REMOVE, 8'hff, 16'hffff);
    send_beat(OP_REMOVE, '0, '0);
    drain_results();
  endtask

  // fill to capacity, drop inserts while full, then empty it again
  task automatic test_full_queue();
    for (int i = 0; i < CAPACITY; i++)
      send_beat(OP_INSERT, PRIO_W'(i % 3), TAG_W'(16'ha000 + i));
    send_beat(OP_INSERT, 8'hff, 16'hbeef);
    send_beat(OP_INSERT, 8'h00, 16'h0001);
    for (int i = 0; i <= CAPACITY; i++)
      send_beat(OP_REMOVE, '0, '0);
    drain_results();
  endtask

  // phases of differing insert bias so the queue swings between empty and full
  task automatic test_random_mix(input int n_phases);
    int insert_pct;
    for (int ph = 0; ph < n_phases; ph++) begin
      case ($urandom_range(4))
        0:       insert_pct = 20;
        1:       insert_pct = 45;
        2:       insert_pct = 55;
        3:       insert_pct = 75;
        default: insert_pct = 95;
      endcase
      repeat ($urandom_range(60, 20)) send_random_beat(insert_pct);
    end
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_receiver_hold();
    src_idle_en = 1'b0;
    @(negedge clk_i) hold_request = 1'b1;
    @(posedge clk_i);
    repeat (24) send_random_beat(60);
    src_idle_en = 1'b1;
    drain_results();
  endtask

  // sender pauses until the queue has answered everything
  task automatic test_sender_pause();
    repeat (3) begin
      repeat ($urandom_range(12, 6)) send_random_beat(60);
      drain_results();
    end
  endtask

  // long stretch with no idling on either side
  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (200) send_random_beat(55);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    drain_results();
  endtask

  initial begin
    // falling edge at start so the asynchronous reset takes effect at once
    rst_ni <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_queue();
    test_random_mix(8);
    test_receiver_hold();
    test_random_mix(6);
    test_sender_pause();
    test_full_rate();
    test_random_mix(4);

    in_valid_i <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk_i);

    $display("checked %0d result beats: %0d inserts, %0d removals, %0d full drops,",
             n_checked, n_inserted, n_removed, n_full_drops);
    $display("%0d empty removals, peak fill %0d, with stalls, hold-off and drains",
             n_empty_pops, peak_fill);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("stable_priority_queue test passed");
    end else begin
      $display("stable_priority_queue test failed");
    end
    $finish;
  end

endmodule
